// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker modules of this project.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- src/ntm_pkg.sv -----
// Shared constants and types for the nearest timestamp match block.
// No dependencies; the cell, top level, checker and testbench import this package.
package ntm_pkg;

   localparam int DEPTH_DEF      = 1024;
   localparam int TIME_BITS_DEF  = 48;
   localparam int COORD_BITS_DEF = 32;

   localparam logic [63:0] GAP_RESET = 64'd1000000000000;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_QUERY = 2'd2
   } kind_type;

   // Control part of the search token that walks down the cell chain.
   typedef struct packed {
      logic valid;
      logic found;
   } tok_ctl_type;

endpackage

// ----- src/ntm_if.sv -----
// Channel interfaces of the nearest timestamp match block: request, response, register write.
// Uses no package; widths come from the interface parameters.
interface ntm_req_if #(
   parameter int TIME_BITS  = 48,
   parameter int COORD_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic        [1:0]            kind;
   logic        [TIME_BITS-1:0]  stamp;
   logic signed [COORD_BITS-1:0] pos_x;
   logic signed [COORD_BITS-1:0] pos_y;
   logic signed [COORD_BITS-1:0] pos_z;

   modport source (output valid, kind, stamp, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, kind, stamp, pos_x, pos_y, pos_z, output ready);
endinterface

interface ntm_rsp_if #(
   parameter int TIME_BITS  = 48,
   parameter int COORD_BITS = 32,
   parameter int IDX_BITS   = 10
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] query_x;
   logic signed [COORD_BITS-1:0] query_y;
   logic signed [COORD_BITS-1:0] query_z;
   logic                         found;
   logic        [IDX_BITS-1:0]   match_index;
   logic signed [COORD_BITS-1:0] match_x;
   logic signed [COORD_BITS-1:0] match_y;
   logic signed [COORD_BITS-1:0] match_z;
   logic        [TIME_BITS-1:0]  match_gap;

   modport source (output valid, query_x, query_y, query_z, found, match_index,
                   match_x, match_y, match_z, match_gap, input ready);
   modport sink   (input valid, query_x, query_y, query_z, found, match_index,
                   match_x, match_y, match_z, match_gap, output ready);
endinterface

interface ntm_csr_if #(
   parameter int TIME_BITS = 48
);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- src/ntm_cell.sv -----
// One cell of the search chain: holds one table entry and updates the passing token.
// Depends on ntm_pkg for the token control type.
module ntm_cell import ntm_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int IDX_BITS   = 10,
   parameter int CNT_BITS   = 11,
   parameter int TIME_BITS  = 48,
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic        [IDX_BITS-1:0]   wr_addr,
   input  logic        [TIME_BITS-1:0]  wr_stamp,
   input  logic signed [COORD_BITS-1:0] wr_x,
   input  logic signed [COORD_BITS-1:0] wr_y,
   input  logic signed [COORD_BITS-1:0] wr_z,
   input  logic        [CNT_BITS-1:0]   count,
   input  logic        [TIME_BITS-1:0]  q_stamp,
   input  tok_ctl_type                  in_ctl,
   input  logic        [IDX_BITS-1:0]   in_idx,
   input  logic        [TIME_BITS-1:0]  in_gap,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  logic signed [COORD_BITS-1:0] in_z,
   output tok_ctl_type                  out_ctl,
   output logic        [IDX_BITS-1:0]   out_idx,
   output logic        [TIME_BITS-1:0]  out_gap,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic signed [COORD_BITS-1:0] out_z
);

   logic        [TIME_BITS-1:0]  stamp_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, z_ff;
   tok_ctl_type                  ctl_ff;
   logic        [IDX_BITS-1:0]   idx_ff;
   logic        [TIME_BITS-1:0]  gap_ff;
   logic signed [COORD_BITS-1:0] tx_ff, ty_ff, tz_ff;

   logic                 active;
   logic [TIME_BITS-1:0] diff;
   logic                 hit;
   logic                 wr_here;

   assign wr_here = wr_en && (wr_addr == IDX_BITS'(INDEX));
   assign active  = CNT_BITS'(INDEX) < count;
   assign diff    = (q_stamp >= stamp_ff) ? (q_stamp - stamp_ff) : (stamp_ff - q_stamp);
   // Strict compare keeps the earliest entry on a tie.
   assign hit     = in_ctl.valid && active && (diff < in_gap);

   always_ff @(posedge clock) begin
      if (wr_here) begin
         stamp_ff <= wr_stamp;
         x_ff     <= wr_x;
         y_ff     <= wr_y;
         z_ff     <= wr_z;
      end
      if (hit) begin
         idx_ff <= IDX_BITS'(INDEX);
         gap_ff <= diff;
         tx_ff  <= x_ff;
         ty_ff  <= y_ff;
         tz_ff  <= z_ff;
      end else begin
         idx_ff <= in_idx;
         gap_ff <= in_gap;
         tx_ff  <= in_x;
         ty_ff  <= in_y;
         tz_ff  <= in_z;
      end
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff.valid <= in_ctl.valid;
         ctl_ff.found <= in_ctl.found || hit;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_idx = idx_ff;
   assign out_gap = gap_ff;
   assign out_x   = tx_ff;
   assign out_y   = ty_ff;
   assign out_z   = tz_ff;

endmodule

// ----- src/nearest_timestamp_match_top.sv -----
// Top level of the nearest timestamp match block: channel control and the chain of cells.
// Depends on ntm_pkg, the interfaces in ntm_if.sv and ntm_cell.
//
//   Channel   Direction  Carries
//   req_bus   in         clear / load / query items (kind, stamp, pos_x/y/z)
//   rsp_bus   out        one result per query (query echo, found, match fields)
//   csr_bus   in         write data for max_gap
//
// Clear and load items are applied at their transfer and do not hold off input. A query
// walks a token through all DEPTH cells, one cell per cycle, then through the pending
// register into the output register; the next item is taken once the result is registered.
// Synchronous active-high reset empties the table and sets max_gap to its default.
// The result waits in the output register while rsp_bus.ready is low; further items are
// taken meanwhile, and the next query's scan runs, but input then stays held off until
// that query's result can move into the output register.
module nearest_timestamp_match_top import ntm_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic clock,
   input  logic reset,
   ntm_req_if.sink   req_bus,
   ntm_rsp_if.source rsp_bus,
   ntm_csr_if.sink   csr_bus
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic        [CNT_BITS-1:0]   count_ff;
   logic        [TIME_BITS-1:0]  max_gap_ff;
   logic        [TIME_BITS-1:0]  q_stamp_ff;
   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;
   logic                         scan_ff;
   logic                         head_valid_ff;

   logic                         pend_valid_ff;
   logic                         pend_found_ff;
   logic        [IDX_BITS-1:0]   pend_idx_ff;
   logic        [TIME_BITS-1:0]  pend_gap_ff;
   logic signed [COORD_BITS-1:0] pend_x_ff, pend_y_ff, pend_z_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic        [IDX_BITS-1:0]   rsp_idx_ff;
   logic        [TIME_BITS-1:0]  rsp_gap_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic signed [COORD_BITS-1:0] rsp_qx_ff, rsp_qy_ff, rsp_qz_ff;

   logic req_xfer, load_xfer, clear_xfer, query_xfer, wr_en, move;

   tok_ctl_type                  tok_ctl [DEPTH+1];
   logic        [IDX_BITS-1:0]   tok_idx [DEPTH+1];
   logic        [TIME_BITS-1:0]  tok_gap [DEPTH+1];
   logic signed [COORD_BITS-1:0] tok_x   [DEPTH+1];
   logic signed [COORD_BITS-1:0] tok_y   [DEPTH+1];
   logic signed [COORD_BITS-1:0] tok_z   [DEPTH+1];

   assign req_bus.ready = !scan_ff;
   assign csr_bus.ready = 1'b1;

   assign req_xfer   = req_bus.valid && req_bus.ready;
   assign clear_xfer = req_xfer && (req_bus.kind == KIND_CLEAR);
   assign load_xfer  = req_xfer && (req_bus.kind == KIND_LOAD);
   assign query_xfer = req_xfer && (req_bus.kind == KIND_QUERY);
   assign wr_en      = load_xfer && (count_ff < CNT_BITS'(DEPTH));
   assign move       = pend_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   // The token starts with the gap limit as its best difference and nothing found.
   assign tok_ctl[0] = '{valid: head_valid_ff, found: 1'b0};
   assign tok_idx[0] = '0;
   assign tok_gap[0] = max_gap_ff;
   assign tok_x[0]   = '0;
   assign tok_y[0]   = '0;
   assign tok_z[0]   = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ntm_cell #(
         .INDEX      (i),
         .IDX_BITS   (IDX_BITS),
         .CNT_BITS   (CNT_BITS),
         .TIME_BITS  (TIME_BITS),
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en),
         .wr_addr  (count_ff[IDX_BITS-1:0]),
         .wr_stamp (req_bus.stamp),
         .wr_x     (req_bus.pos_x),
         .wr_y     (req_bus.pos_y),
         .wr_z     (req_bus.pos_z),
         .count    (count_ff),
         .q_stamp  (q_stamp_ff),
         .in_ctl   (tok_ctl[i]),
         .in_idx   (tok_idx[i]),
         .in_gap   (tok_gap[i]),
         .in_x     (tok_x[i]),
         .in_y     (tok_y[i]),
         .in_z     (tok_z[i]),
         .out_ctl  (tok_ctl[i+1]),
         .out_idx  (tok_idx[i+1]),
         .out_gap  (tok_gap[i+1]),
         .out_x    (tok_x[i+1]),
         .out_y    (tok_y[i+1]),
         .out_z    (tok_z[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (query_xfer) begin
         q_stamp_ff <= req_bus.stamp;
         qx_ff      <= req_bus.pos_x;
         qy_ff      <= req_bus.pos_y;
         qz_ff      <= req_bus.pos_z;
      end
      // Match fields read as zero when nothing was found within the gap.
      if (tok_ctl[DEPTH].valid) begin
         pend_found_ff <= tok_ctl[DEPTH].found;
         pend_idx_ff   <= tok_ctl[DEPTH].found ? tok_idx[DEPTH] : '0;
         pend_gap_ff   <= tok_ctl[DEPTH].found ? tok_gap[DEPTH] : '0;
         pend_x_ff     <= tok_ctl[DEPTH].found ? tok_x[DEPTH] : '0;
         pend_y_ff     <= tok_ctl[DEPTH].found ? tok_y[DEPTH] : '0;
         pend_z_ff     <= tok_ctl[DEPTH].found ? tok_z[DEPTH] : '0;
      end
      if (move) begin
         rsp_found_ff <= pend_found_ff;
         rsp_idx_ff   <= pend_idx_ff;
         rsp_gap_ff   <= pend_gap_ff;
         rsp_x_ff     <= pend_x_ff;
         rsp_y_ff     <= pend_y_ff;
         rsp_z_ff     <= pend_z_ff;
         rsp_qx_ff    <= qx_ff;
         rsp_qy_ff    <= qy_ff;
         rsp_qz_ff    <= qz_ff;
      end
      if (reset) begin
         count_ff      <= '0;
         max_gap_ff    <= TIME_BITS'(GAP_RESET);
         scan_ff       <= 1'b0;
         head_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            max_gap_ff <= csr_bus.data;
         end
         if (clear_xfer) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + 1'b1;
         end
         head_valid_ff <= query_xfer;
         if (query_xfer) begin
            scan_ff <= 1'b1;
         end else if (move) begin
            scan_ff <= 1'b0;
         end
         if (tok_ctl[DEPTH].valid) begin
            pend_valid_ff <= 1'b1;
         end else if (move) begin
            pend_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.query_x     = rsp_qx_ff;
   assign rsp_bus.query_y     = rsp_qy_ff;
   assign rsp_bus.query_z     = rsp_qz_ff;
   assign rsp_bus.found       = rsp_found_ff;
   assign rsp_bus.match_index = rsp_idx_ff;
   assign rsp_bus.match_x     = rsp_x_ff;
   assign rsp_bus.match_y     = rsp_y_ff;
   assign rsp_bus.match_z     = rsp_z_ff;
   assign rsp_bus.match_gap   = rsp_gap_ff;

endmodule

// ----- src/ntm_checker.sv -----
// Port-level checks for the nearest timestamp match block, attached to the top by bind.
// Depends on ntm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ntm_checker import ntm_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF,
   parameter int IDX_BITS  = 10
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [1:0]           req_kind,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_found,
   input logic [IDX_BITS-1:0]  rsp_match_index,
   input logic [TIME_BITS-1:0] rsp_match_gap
);

   // A waiting result stays offered until it is taken.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A result without a match carries zero index and zero difference.
   `ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_found,
                rsp_match_index == '0 && rsp_match_gap == '0)

   // A query transfer makes the block busy until its result is registered.
   `ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_kind == KIND_QUERY,
                !req_ready)

   // Coming out of reset the block is idle with no result pending.
   `ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, req_ready && !rsp_valid)

endmodule

bind nearest_timestamp_match_top ntm_checker #(
   .TIME_BITS (TIME_BITS),
   .IDX_BITS  (IDX_BITS)
) u_ntm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_kind        (req_bus.kind),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_found       (rsp_bus.found),
   .rsp_match_index (rsp_bus.match_index),
   .rsp_match_gap   (rsp_bus.match_gap)
);

// ----- bench/tb.sv -----
// Self-checking testbench for nearest_timestamp_match_top: clear, load and query traffic
// with random pacing on the request and response channels, checked against a built-in nearest-stamp predictor.
// Depends on ntm_pkg, the channel interfaces in ntm_if.sv and the block's RTL.
module tb import ntm_pkg::*;;

   localparam int N_ENTRIES = DEPTH_DEF;
   localparam int TW        = TIME_BITS_DEF;
   localparam int CW        = COORD_BITS_DEF;
   localparam int IW        = $clog2(DEPTH_DEF);

   localparam logic [1:0]    KIND_UNUSED  = 2'd3;
   localparam logic [TW-1:0] STAMP_MAX    = {TW{1'b1}};
   localparam int            SQUEEZE_CYC  = 4000;
   localparam int            SETTLE_CYC   = N_ENTRIES + 8;
   localparam longint        LIMIT_CYCLES = 3_000_000;

   typedef struct {
      logic signed [CW-1:0] query_x;
      logic signed [CW-1:0] query_y;
      logic signed [CW-1:0] query_z;
      logic                 found;
      logic [IW-1:0]        entry;
      logic signed [CW-1:0] near_x;
      logic signed [CW-1:0] near_y;
      logic signed [CW-1:0] near_z;
      logic [TW-1:0]        gap;
   } match_result;

   class match_board;
      logic [TW-1:0] ref_stamp [N_ENTRIES];
      logic [CW-1:0] ref_px [N_ENTRIES];
      logic [CW-1:0] ref_py [N_ENTRIES];
      logic [CW-1:0] ref_pz [N_ENTRIES];
      int unsigned   loaded;
      logic [TW-1:0] gap_limit;
      match_result   expected_matches [$];
      int            mismatches;

      function new();
         loaded     = 0;
         gap_limit  = GAP_RESET[TW-1:0];
         mismatches = 0;
      endfunction

      // Applies one accepted request to the table and queues the answer of a query.
      function void note_item(logic [1:0] kind, logic [TW-1:0] stamp,
                              logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
         match_result   r;
         logic [TW-1:0] best;
         logic [TW-1:0] d;
         int            pick;
         bit            hit;
         int            i;
         case (kind)
            KIND_CLEAR: begin
               loaded = 0;
            end
            KIND_LOAD: begin
               if (loaded < N_ENTRIES) begin
                  ref_stamp[loaded] = stamp;
                  ref_px[loaded]    = x;
                  ref_py[loaded]    = y;
                  ref_pz[loaded]    = z;
                  loaded++;
               end
            end
            KIND_QUERY: begin
               best = gap_limit;
               hit  = 1'b0;
               pick = 0;
               // Strictly-less keeps the earliest entry on a tie.
               for (i = 0; i < loaded; i++) begin
                  d = (stamp >= ref_stamp[i]) ? stamp - ref_stamp[i] : ref_stamp[i] - stamp;
                  if (d < best) begin
                     best = d;
                     pick = i;
                     hit  = 1'b1;
                  end
               end
               r.query_x = x;
               r.query_y = y;
               r.query_z = z;
               r.found   = hit;
               r.entry   = hit ? pick[IW-1:0] : '0;
               r.near_x  = hit ? ref_px[pick] : '0;
               r.near_y  = hit ? ref_py[pick] : '0;
               r.near_z  = hit ? ref_pz[pick] : '0;
               r.gap     = hit ? best : '0;
               expected_matches = {expected_matches, r};
            end
            default: ;
         endcase
      endfunction

      task flag(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            flag($sformatf("%s got %0h, expected %0h", name, got, want));
      endtask

      task check_match(match_result got);
         match_result want;
         if (expected_matches.size() == 0) begin
            flag("result transfer with no query outstanding");
            return;
         end
         want = expected_matches.pop_front();
         compare_field("query_x", 64'($unsigned(got.query_x)), 64'($unsigned(want.query_x)));
         compare_field("query_y", 64'($unsigned(got.query_y)), 64'($unsigned(want.query_y)));
         compare_field("query_z", 64'($unsigned(got.query_z)), 64'($unsigned(want.query_z)));
         compare_field("found", 64'(got.found), 64'(want.found));
         compare_field("match_index", 64'(got.entry), 64'(want.entry));
         compare_field("match_x", 64'($unsigned(got.near_x)), 64'($unsigned(want.near_x)));
         compare_field("match_y", 64'($unsigned(got.near_y)), 64'($unsigned(want.near_y)));
         compare_field("match_z", 64'($unsigned(got.near_z)), 64'($unsigned(want.near_z)));
         compare_field("match_gap", 64'(got.gap), 64'(want.gap));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ntm_req_if #(.TIME_BITS(TW), .COORD_BITS(CW))             req_bus ();
   ntm_rsp_if #(.TIME_BITS(TW), .COORD_BITS(CW), .IDX_BITS(IW)) rsp_bus ();
   ntm_csr_if #(.TIME_BITS(TW))                              csr_bus ();

   nearest_timestamp_match_top #(
      .DEPTH      (N_ENTRIES),
      .TIME_BITS  (TW),
      .COORD_BITS (CW)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   match_board    board;
   int            burst_left;
   int            spread_bits;
   logic [TW-1:0] phase_base;
   bit            squeeze_req  = 1'b0;
   bit            squeeze_done = 1'b0;

   function automatic logic [TW-1:0] rand_stamp();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[TW-1:0];
   endfunction

   // Stamps cluster around the phase base so that queries find close entries.
   function automatic logic [TW-1:0] near_stamp();
      logic [TW-1:0] off;
      off = rand_stamp();
      if (spread_bits < TW)
         off = off & ((48'd1 << spread_bits) - 48'd1);
      return phase_base + off;
   endfunction

   // One request transfer, followed by the sender's burst and gap pacing.
   task automatic send_item(logic [1:0] kind, logic [TW-1:0] stamp,
                            logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
      int idle;
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.stamp <= stamp;
      req_bus.pos_x <= x;
      req_bus.pos_y <= y;
      req_bus.pos_z <= z;
      do @(posedge clock); while (!req_bus.ready);
      board.note_item(kind, stamp, x, y, z);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 12);
         idle = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
         if (idle > 0) begin
            req_bus.valid <= 1'b0;
            repeat (idle) @(posedge clock);
         end
      end
   endtask

   // Waits out every outstanding query and then a margin longer than a query's scan of the chain.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_gap(logic [TW-1:0] value);
      settle();
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      board.gap_limit = value;
   endtask

   // Mostly well-formed traffic: a clear, then loads and queries, with some stray items.
   task automatic random_phase(int bits, logic [TW-1:0] gap, int items, bit squeeze);
      int n;
      int pick;
      write_gap(gap);
      spread_bits = bits;
      phase_base  = rand_stamp();
      send_item(KIND_CLEAR, rand_stamp(), $urandom(), $urandom(), $urandom());
      for (n = 0; n < items; n++) begin
         if (n == 5 && squeeze)
            squeeze_req = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 4)
            send_item(KIND_UNUSED, rand_stamp(), $urandom(), $urandom(), $urandom());
         else if (pick < 8)
            send_item(KIND_CLEAR, rand_stamp(), $urandom(), $urandom(), $urandom());
         else if (pick < 60)
            send_item(KIND_LOAD, near_stamp(), $urandom(), $urandom(), $urandom());
         else
            send_item(KIND_QUERY, near_stamp(), $urandom(), $urandom(), $urandom());
      end
   endtask

   // Receiver: stretches of full, partial or no readiness, plus one long hold-off.
   initial begin : drive_rsp_ready
      int mode;
      int len;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (squeeze_req && !squeeze_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (SQUEEZE_CYC) @(posedge clock);
            squeeze_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 40);
         repeat (len) begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      match_result got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.query_x = rsp_bus.query_x;
         got.query_y = rsp_bus.query_y;
         got.query_z = rsp_bus.query_z;
         got.found   = rsp_bus.found;
         got.entry   = rsp_bus.match_index;
         got.near_x  = rsp_bus.match_x;
         got.near_y  = rsp_bus.match_y;
         got.near_z  = rsp_bus.match_z;
         got.gap     = rsp_bus.match_gap;
         board.check_match(got);
      end
   end

   initial begin : stimulus
      board = new();
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_CLEAR;
      req_bus.stamp <= '0;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      req_bus.pos_z <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.data  <= '0;
      burst_left  = 4;
      spread_bits = 8;
      phase_base  = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the default gap: empty table, unused kind, stamp extremes, ties.
      send_item(KIND_QUERY, 48'd77, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      send_item(KIND_UNUSED, STAMP_MAX, 32'hffff_ffff, 32'h0, 32'h1234_5678);
      send_item(KIND_LOAD, 48'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
      send_item(KIND_LOAD, STAMP_MAX, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      send_item(KIND_LOAD, 48'd5000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      send_item(KIND_LOAD, 48'd5000, 32'hffff_0000, 32'hfffe_0000, 32'hfffd_0000);
      send_item(KIND_QUERY, 48'd5000, 32'h1, 32'h2, 32'h3);
      send_item(KIND_LOAD, 48'd6000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000);
      // Equally far from 5000 and 6000: the earlier entry wins.
      send_item(KIND_QUERY, 48'd5500, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
      send_item(KIND_QUERY, STAMP_MAX, 32'h0, 32'hffff_ffff, 32'h8000_0000);
      send_item(KIND_QUERY, 48'h8000_0000_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h1);
      send_item(KIND_CLEAR, 48'd0, 32'h0, 32'h0, 32'h0);
      send_item(KIND_QUERY, 48'd5000, 32'h1, 32'h1, 32'h1);
      send_item(KIND_LOAD, 48'd100, 32'h0badc0de, 32'hdeadbeef, 32'h0000_ffff);
      send_item(KIND_QUERY, 48'd100, 32'h0, 32'h0, 32'h0);

      // With a zero gap nothing can match.
      write_gap('0);
      send_item(KIND_QUERY, 48'd100, 32'h1, 32'h2, 32'h3);

      // Largest gap: a difference equal to it still misses.
      write_gap(STAMP_MAX);
      send_item(KIND_CLEAR, 48'd0, 32'h0, 32'h0, 32'h0);
      send_item(KIND_LOAD, 48'd0, 32'hcafe_f00d, 32'h8000_0001, 32'h7fff_fffe);
      send_item(KIND_QUERY, STAMP_MAX, 32'h1, 32'h2, 32'h3);
      send_item(KIND_QUERY, STAMP_MAX - 48'd1, 32'h4, 32'h5, 32'h6);

      write_gap(48'd1);
      send_item(KIND_QUERY, 48'd0, 32'h7, 32'h8, 32'h9);
      send_item(KIND_QUERY, 48'd1, 32'ha, 32'hb, 32'hc);

      random_phase(4, 48'd3, 80, 1'b0);
      random_phase(12, GAP_RESET[TW-1:0], 80, 1'b0);
      random_phase(20, 48'($urandom_range(0, 1 << 18)), 90, 1'b1);
      random_phase(40, rand_stamp() >> 10, 80, 1'b0);
      random_phase(TW, STAMP_MAX, 80, 1'b0);
      random_phase(30, '0, 40, 1'b0);
      random_phase(8, 48'd1, 80, 1'b0);

      settle();
      if (board.mismatches == 0 && board.expected_matches.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * 12);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
